FILE: rtl/bilinear_image_scaler_assert.svh
// Assertion macros for the bilinear image scaler.
`ifndef BILINEAR_IMAGE_SCALER_ASSERT_SVH
`define BILINEAR_IMAGE_SCALER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BIS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BIS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bis_pkg.sv
// Constants and register codes shared by the bilinear image scaler.
package bis_pkg;
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int FRAC_BITS  = 8;

    localparam int XW   = $clog2(MAX_WIDTH);              // source column bits
    localparam int YW   = $clog2(MAX_HEIGHT);             // source row bits
    localparam int AW   = XW + YW;                        // frame store address bits
    localparam int CW   = 12;                             // coordinate bits
    localparam int DW   = 13;                             // destination size bits
    localparam int SW   = 10;                             // source size bits
    localparam int NUMW = CW + XW;                        // coordinate times (size-1)
    localparam int QW   = XW + FRAC_BITS;                 // quotient bits
    localparam int WW   = 2 * FRAC_BITS + 1;              // blend weight bits
    localparam int ACCW = 8 + 2 * FRAC_BITS;              // channel sum bits

    typedef enum logic [2:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_DST_WIDTH  = 3'd2,
        REG_DST_HEIGHT = 3'd3,
        REG_CH_COUNT   = 3'd4
    } t_reg_idx;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;
endpackage

FILE: rtl/bilinear_image_scaler.sv
// Bilinear image scaler: source frame store, coordinate divider and blend sequencer.
//
// Input channel (i_in_valid/o_in_ready): a load writes one 32-bit pixel into the
// frame store at (coord_x, coord_y); a sample maps a destination coordinate to the
// source as dst*(S-1)/D and returns one blended pixel on the output channel
// (o_out_valid/i_out_ready). Rejected loads and samples outside the configured
// size return one result with status 1 and zero channels.
// Configuration (i_cfg_valid/i_cfg_index/i_cfg_data) is always ready and takes
// effect on the next item; write it only while the block is idle.
// An accepted load gives no result. A sample passes through one multiply,
// 17 restoring-division steps (one quotient bit a cycle for both axes together),
// a weight step, four reads of the single-port frame memory through its registered
// read, and the load of the output register; the input is ready again once the
// sequencer is back in idle.
// Error results appear in the cycle after the transfer.
// The frame store has no reset; entries never loaded read as anything.
// Reset clears the sequencer and the output valid and sets the configuration to its defaults.
// While the receiver stalls, the result holds in the output register; a new item
// is taken only when that register is empty or is being drained.
module bilinear_image_scaler
    import bis_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_command,
    input  logic [CW-1:0]     i_coord_x,
    input  logic [CW-1:0]     i_coord_y,
    input  logic [7:0]        i_in_ch0,
    input  logic [7:0]        i_in_ch1,
    input  logic [7:0]        i_in_ch2,
    input  logic [7:0]        i_in_ch3,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_ch0,
    output logic [7:0]        o_out_ch1,
    output logic [7:0]        o_out_ch2,
    output logic [7:0]        o_out_ch3,
    output logic              o_status,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [DW-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DIV, S_WGT, S_RD, S_OUT
    } t_state;

    // configuration
    logic [SW-1:0] r_src_w, r_src_h;
    logic [DW-1:0] r_dst_w, r_dst_h;
    logic [2:0]    r_nch;

    // sequencer and datapath
    t_state          r_state;
    logic [4:0]      r_div_cnt;
    logic [2:0]      r_rd_cnt;
    logic [CW-1:0]   r_dx, r_dy;
    logic [DW-1:0]   r_remx, r_remy;
    logic [QW-1:0]   r_qx, r_qy;
    logic [XW-1:0]   r_x1, r_x2;
    logic [YW-1:0]   r_y1, r_y2;
    logic [WW-1:0]   r_w [4];
    logic [ACCW-1:0] r_acc [4];
    logic [31:0]     r_rdata;
    logic [31:0]     r_mem [MAX_WIDTH*MAX_HEIGHT];

    // output register
    logic       r_ov, r_status;
    logic [7:0] r_och [4];

    // effective sizes
    logic [SW-1:0] sw_eff, sh_eff;
    logic [2:0]    nch_eff;
    logic          in_xfer, out_free, load_ok, samp_ok;
    logic          err_xfer, n_ov;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [31:0]   load_word;

    always_comb begin
        sw_eff  = (r_src_w == '0) ? SW'(1) :
                  (r_src_w > SW'(MAX_WIDTH)) ? SW'(MAX_WIDTH) : r_src_w;
        sh_eff  = (r_src_h == '0) ? SW'(1) :
                  (r_src_h > SW'(MAX_HEIGHT)) ? SW'(MAX_HEIGHT) : r_src_h;
        nch_eff = (r_nch > 3'd4) ? 3'd4 : r_nch;
    end

    assign out_free    = !r_ov || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && out_free;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign load_ok     = ({1'b0, i_coord_x} < (CW+1)'(sw_eff)) &&
                         ({1'b0, i_coord_y} < (CW+1)'(sh_eff));
    assign samp_ok     = ({1'b0, i_coord_x} < r_dst_w) && ({1'b0, i_coord_y} < r_dst_h);
    assign load_word   = {i_in_ch3, i_in_ch2, i_in_ch1, i_in_ch0};
    assign mem_we      = in_xfer && (i_command == CMD_LOAD) && load_ok;
    assign err_xfer    = in_xfer && ((i_command == CMD_LOAD) ? !load_ok : !samp_ok);

    // Output valid: drop on a drained transfer, raise on an error or a finished blend.
    always_comb begin
        n_ov = r_ov && !i_out_ready;
        if (err_xfer || (r_state == S_OUT && out_free)) begin
            n_ov = 1'b1;
        end
    end

    // Neighbour order: top-left, top-right, bottom-left, bottom-right.
    always_comb begin
        if (r_state == S_IDLE) begin
            mem_addr = {i_coord_y[YW-1:0], i_coord_x[XW-1:0]};
        end else begin
            unique case (r_rd_cnt[1:0])
                2'd0:    mem_addr = {r_y1, r_x1};
                2'd1:    mem_addr = {r_y1, r_x2};
                2'd2:    mem_addr = {r_y2, r_x1};
                default: mem_addr = {r_y2, r_x2};
            endcase
        end
    end

    // Single-port frame memory, registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= load_word;
        end
        r_rdata <= r_mem[mem_addr];
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SW'(512);
            r_src_h <= SW'(512);
            r_dst_w <= DW'(512);
            r_dst_h <= DW'(512);
            r_nch   <= 3'd3;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SRC_WIDTH:  r_src_w <= i_cfg_data[SW-1:0];
                REG_SRC_HEIGHT: r_src_h <= i_cfg_data[SW-1:0];
                REG_DST_WIDTH:  r_dst_w <= i_cfg_data;
                REG_DST_HEIGHT: r_dst_h <= i_cfg_data;
                REG_CH_COUNT:   r_nch   <= i_cfg_data[2:0];
                default:        ;
            endcase
        end
    end

    // Division step for both axes: one quotient bit each.
    logic [DW:0]         tx, ty;
    logic                gex, gey;
    logic [NUMW-1:0]     prodx, prody;
    logic [FRAC_BITS:0]  fxc, fyc;
    logic [XW:0]         x1p;
    logic [YW:0]         y1p;
    logic [WW-1:0]       w_sel;

    always_comb begin
        tx    = {r_remx, r_qx[QW-1]};
        ty    = {r_remy, r_qy[QW-1]};
        gex   = tx >= {1'b0, r_dst_w};
        gey   = ty >= {1'b0, r_dst_h};
        prodx = NUMW'(r_dx * (sw_eff - SW'(1)));
        prody = NUMW'(r_dy * (sh_eff - SW'(1)));
        fxc   = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, r_qx[FRAC_BITS-1:0]};
        fyc   = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, r_qy[FRAC_BITS-1:0]};
        x1p   = {1'b0, r_qx[QW-1:FRAC_BITS]} + (XW+1)'(1);
        y1p   = {1'b0, r_qy[QW-1:FRAC_BITS]} + (YW+1)'(1);
        w_sel = r_w[2'(r_rd_cnt - 3'd1)];
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ov      <= 1'b0;
            r_div_cnt <= '0;
            r_rd_cnt  <= '0;
        end else begin
            r_ov <= n_ov;
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_dx <= i_coord_x;
                        r_dy <= i_coord_y;
                        if (i_command == CMD_LOAD) begin
                            if (!load_ok) begin
                                r_status <= 1'b1;
                                for (int c = 0; c < 4; c++) r_och[c] <= '0;
                            end
                        end else if (!samp_ok) begin
                            r_status <= 1'b1;
                            for (int c = 0; c < 4; c++) r_och[c] <= '0;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    // dividend is (coord*(size-1)) shifted up by the fraction bits
                    r_remx    <= DW'(prodx[NUMW-1:XW]);
                    r_remy    <= DW'(prody[NUMW-1:XW]);
                    r_qx      <= {prodx[XW-1:0], FRAC_BITS'(0)};
                    r_qy      <= {prody[XW-1:0], FRAC_BITS'(0)};
                    r_div_cnt <= 5'(QW - 1);
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    r_remx <= gex ? DW'(tx - {1'b0, r_dst_w}) : DW'(tx);
                    r_remy <= gey ? DW'(ty - {1'b0, r_dst_h}) : DW'(ty);
                    r_qx   <= {r_qx[QW-2:0], gex};
                    r_qy   <= {r_qy[QW-2:0], gey};
                    if (r_div_cnt == '0) begin
                        r_state <= S_WGT;
                    end else begin
                        r_div_cnt <= r_div_cnt - 5'd1;
                    end
                end
                S_WGT: begin
                    r_x1 <= r_qx[QW-1:FRAC_BITS];
                    r_y1 <= r_qy[QW-1:FRAC_BITS];
                    // clamp right and bottom neighbours to the last column and row
                    r_x2 <= (x1p < (XW+1)'(sw_eff)) ? x1p[XW-1:0] : XW'(sw_eff - SW'(1));
                    r_y2 <= (y1p < (YW+1)'(sh_eff)) ? y1p[YW-1:0] : YW'(sh_eff - SW'(1));
                    r_w[0] <= WW'(fxc * fyc);
                    r_w[1] <= WW'({1'b0, r_qx[FRAC_BITS-1:0]} * fyc);
                    r_w[2] <= WW'(fxc * {1'b0, r_qy[FRAC_BITS-1:0]});
                    r_w[3] <= WW'(r_qx[FRAC_BITS-1:0] * r_qy[FRAC_BITS-1:0]);
                    for (int c = 0; c < 4; c++) r_acc[c] <= '0;
                    r_rd_cnt <= '0;
                    r_state  <= S_RD;
                end
                S_RD: begin
                    // read data is registered and lags its address; nothing is accumulated at rd_cnt 0
                    if (r_rd_cnt != '0) begin
                        for (int c = 0; c < 4; c++) begin
                            r_acc[c] <= r_acc[c] + ACCW'(r_rdata[8*c +: 8] * w_sel);
                        end
                    end
                    if (r_rd_cnt == 3'd4) begin
                        r_state <= S_OUT;
                    end else begin
                        r_rd_cnt <= r_rd_cnt + 3'd1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_status <= 1'b0;
                        for (int c = 0; c < 4; c++) begin
                            r_och[c] <= (3'(c) < nch_eff) ?
                                        r_acc[c][ACCW-1:2*FRAC_BITS] : 8'd0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_status    = r_status;
    assign o_out_ch0   = r_och[0];
    assign o_out_ch1   = r_och[1];
    assign o_out_ch2   = r_och[2];
    assign o_out_ch3   = r_och[3];

`include "bilinear_image_scaler_assert.svh"

    `BIS_ASSERT_IMP(a_ready_idle, o_in_ready, r_state == S_IDLE, "ready outside idle")
    `BIS_ASSERT_NXT(a_div_done, r_state == S_DIV && r_div_cnt == '0, r_state == S_WGT,
                    "divider overran")
    `BIS_ASSERT_NXT(a_rd_done, r_state == S_RD && r_rd_cnt == 3'd4, r_state == S_OUT,
                    "read sequence overran")
    `BIS_ASSERT_IMP(a_err_zero, o_out_valid && o_status,
                    o_out_ch0 == 8'd0 && o_out_ch1 == 8'd0 && o_out_ch2 == 8'd0 &&
                    o_out_ch3 == 8'd0, "error result carries data")

endmodule

FILE: sim/bilinear_image_scaler_tb.sv
// Self-checking testbench for the bilinear image scaler: loads, samples and config phases.
module bilinear_image_scaler_tb;
    import bis_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 900000;
    localparam int DRAIN_WAIT  = 40;
    localparam int STORE_WORDS = MAX_WIDTH * MAX_HEIGHT;

    typedef struct {
        logic          cmd;
        int unsigned   x;
        int unsigned   y;
        logic [7:0]    ch [4];
    } t_pixel_cmd;

    typedef struct {
        logic [7:0] ch [4];
        logic       status;
    } t_pixel_out;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic              i_command = CMD_LOAD;
    logic [CW-1:0]     i_coord_x = '0;
    logic [CW-1:0]     i_coord_y = '0;
    logic [7:0]        i_in_ch0 = '0;
    logic [7:0]        i_in_ch1 = '0;
    logic [7:0]        i_in_ch2 = '0;
    logic [7:0]        i_in_ch3 = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [7:0]        o_out_ch0;
    logic [7:0]        o_out_ch1;
    logic [7:0]        o_out_ch2;
    logic [7:0]        o_out_ch3;
    logic              o_status;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [2:0]        i_cfg_index = REG_SRC_WIDTH;
    logic [DW-1:0]     i_cfg_data = '0;

    bilinear_image_scaler dut (.*);

    // Scaler registers as the predictor sees them (raw values, reset state)
    int unsigned src_w_reg = 512, src_h_reg = 512, dst_w_reg = 512, dst_h_reg = 512;
    int unsigned ch_count_reg = 3;

    logic [31:0] pixel_mem [STORE_WORDS];   // predicted frame store
    bit          loaded    [STORE_WORDS];   // entries covered by queued loads

    t_pixel_cmd  pending_cmds [$];
    t_pixel_out  expected_pixels [$];
    t_pixel_cmd  cur_cmd;

    int          snd_idle_pct = 19;
    int          rcv_idle_pct = 80;
    int          hold_token = 0;
    int          hold_seen = 0;
    int          hold_cnt = 0;
    int          mismatches = 0;
    int          cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_src_w();
        return (src_w_reg == 0) ? 1 : (src_w_reg > MAX_WIDTH) ? MAX_WIDTH : src_w_reg;
    endfunction

    function automatic int unsigned eff_src_h();
        return (src_h_reg == 0) ? 1 : (src_h_reg > MAX_HEIGHT) ? MAX_HEIGHT : src_h_reg;
    endfunction

    // Map a destination coordinate onto the source grid: integer part and fraction
    function automatic void map_axis(input int unsigned d, input int unsigned s,
                                     input int unsigned dsize,
                                     output int unsigned ipart, output int unsigned frac);
        int unsigned num;
        num   = d * (s - 1);
        ipart = num / dsize;
        frac  = ((num % dsize) << FRAC_BITS) / dsize;
    endfunction

    // Work out the four neighbour positions of a sample, clamped at right and bottom
    function automatic void neighbours(input int unsigned x, input int unsigned y,
                                       output int unsigned x1, output int unsigned x2,
                                       output int unsigned y1, output int unsigned y2,
                                       output int unsigned fx, output int unsigned fy);
        int unsigned sw;
        int unsigned sh;
        sw = eff_src_w();
        sh = eff_src_h();
        map_axis(x, sw, dst_w_reg, x1, fx);
        map_axis(y, sh, dst_h_reg, y1, fy);
        x2 = (x1 + 1 < sw) ? x1 + 1 : sw - 1;
        y2 = (y1 + 1 < sh) ? y1 + 1 : sh - 1;
    endfunction

    // Apply one accepted command to the predicted store and queue its result, if it gives one
    task automatic predict_pixel(input t_pixel_cmd c);
        t_pixel_out  r;
        int unsigned x1, x2, y1, y2, fx, fy, nch;
        longint unsigned w1, w2, w3, w4, acc;
        logic [31:0] p1, p2, p3, p4;
        for (int k = 0; k < 4; k++) r.ch[k] = '0;
        r.status = 1'b0;
        if (c.cmd == CMD_LOAD) begin
            if (c.x >= eff_src_w() || c.y >= eff_src_h()) begin
                r.status = 1'b1;
                expected_pixels.push_back(r);
            end else begin
                pixel_mem[c.y * MAX_WIDTH + c.x] = {c.ch[3], c.ch[2], c.ch[1], c.ch[0]};
            end
            return;
        end
        if (c.x >= dst_w_reg || c.y >= dst_h_reg) begin
            r.status = 1'b1;
            expected_pixels.push_back(r);
            return;
        end
        neighbours(c.x, c.y, x1, x2, y1, y2, fx, fy);
        w1 = (256 - fx) * (256 - fy);
        w2 = fx * (256 - fy);
        w3 = (256 - fx) * fy;
        w4 = fx * fy;
        p1 = pixel_mem[y1 * MAX_WIDTH + x1];
        p2 = pixel_mem[y1 * MAX_WIDTH + x2];
        p3 = pixel_mem[y2 * MAX_WIDTH + x1];
        p4 = pixel_mem[y2 * MAX_WIDTH + x2];
        nch = (ch_count_reg > 4) ? 4 : ch_count_reg;
        for (int k = 0; k < 4; k++) begin
            if (k < nch) begin
                acc = p1[8*k +: 8] * w1 + p2[8*k +: 8] * w2
                    + p3[8*k +: 8] * w3 + p4[8*k +: 8] * w4;
                r.ch[k] = acc[2*FRAC_BITS +: 8];
            end
        end
        expected_pixels.push_back(r);
    endtask

    function automatic logic [7:0] rand_byte();
        int unsigned pick;
        pick = $urandom_range(9);
        return (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
    endfunction

    task automatic queue_load(input int unsigned x, input int unsigned y);
        t_pixel_cmd c;
        c.cmd = CMD_LOAD;
        c.x   = x;
        c.y   = y;
        for (int k = 0; k < 4; k++) c.ch[k] = rand_byte();
        if (x < eff_src_w() && y < eff_src_h()) loaded[y * MAX_WIDTH + x] = 1'b1;
        pending_cmds.push_back(c);
    endtask

    // Queue a sample, preceded by loads for any neighbour not yet written
    task automatic queue_sample(input int unsigned x, input int unsigned y);
        t_pixel_cmd  c;
        int unsigned x1, x2, y1, y2, fx, fy;
        if (x < dst_w_reg && y < dst_h_reg) begin
            neighbours(x, y, x1, x2, y1, y2, fx, fy);
            if (!loaded[y1 * MAX_WIDTH + x1]) queue_load(x1, y1);
            if (!loaded[y1 * MAX_WIDTH + x2]) queue_load(x2, y1);
            if (!loaded[y2 * MAX_WIDTH + x1]) queue_load(x1, y2);
            if (!loaded[y2 * MAX_WIDTH + x2]) queue_load(x2, y2);
        end
        c.cmd = CMD_SAMPLE;
        c.x   = x;
        c.y   = y;
        for (int k = 0; k < 4; k++) c.ch[k] = rand_byte();
        pending_cmds.push_back(c);
    endtask

    // Coordinate mostly near the valid range, now and then anywhere in 12 bits
    function automatic int unsigned rand_coord(input int unsigned lim);
        if ($urandom_range(9) == 0) return $urandom_range(4095);
        return $urandom_range((lim + 1 > 4095) ? 4095 : lim + 1);
    endfunction

    task automatic write_reg(input t_reg_idx idx, input int unsigned value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= DW'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_SRC_WIDTH:  src_w_reg    = value & 32'h3FF;
            REG_SRC_HEIGHT: src_h_reg    = value & 32'h3FF;
            REG_DST_WIDTH:  dst_w_reg    = value & 32'h1FFF;
            REG_DST_HEIGHT: dst_h_reg    = value & 32'h1FFF;
            REG_CH_COUNT:   ch_count_reg = value & 32'h7;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    // Hold until every queued command is taken and every result is back
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || expected_pixels.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Input driver: transfer on valid && ready, then advance to the next command
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) predict_pixel(cur_cmd);
            if (!i_in_valid || o_in_ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                    cur_cmd = pending_cmds.pop_front();
                    i_command  <= cur_cmd.cmd;
                    i_coord_x  <= CW'(cur_cmd.x);
                    i_coord_y  <= CW'(cur_cmd.y);
                    i_in_ch0   <= cur_cmd.ch[0];
                    i_in_ch1   <= cur_cmd.ch[1];
                    i_in_ch2   <= cur_cmd.ch[2];
                    i_in_ch3   <= cur_cmd.ch[3];
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output ready: random stalls, plus a long hold-off whenever one is requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_seen != hold_token) begin
            hold_seen   <= hold_token;
            hold_cnt    <= 400;
            i_out_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt    <= hold_cnt - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Result monitor: compare each transfer with the oldest expected pixel
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: ch %h %h %h %h status %b",
                             o_out_ch3, o_out_ch2, o_out_ch1, o_out_ch0, o_status);
            end else begin
                t_pixel_out e;
                e = expected_pixels.pop_front();
                if (o_out_ch0 !== e.ch[0] || o_out_ch1 !== e.ch[1] ||
                    o_out_ch2 !== e.ch[2] || o_out_ch3 !== e.ch[3] ||
                    o_status !== e.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected ch %h %h %h %h st %b, got %h %h %h %h st %b",
                                 e.ch[3], e.ch[2], e.ch[1], e.ch[0], e.status,
                                 o_out_ch3, o_out_ch2, o_out_ch1, o_out_ch0, o_status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Config phases: src_w, src_h, dst_w, dst_h, channel_count, random commands
    int unsigned phase_cfg [7][6] = '{
        '{4,   3,    7,    5,  4, 200},
        '{16,  16,   5,    9,  1, 200},
        '{1,   1,    1,    1,  2, 160},
        '{512, 512,  4096, 4096, 4, 80},
        '{0,   1023, 0,    13, 0, 160},
        '{9,   2,    4096, 1,  7, 200},
        '{33,  20,   64,   40, 3, 200}
    };

    initial begin
        for (int k = 0; k < STORE_WORDS; k++) begin
            pixel_mem[k] = '0;
            loaded[k]    = 1'b0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corners, rejected loads, samples at and beyond the edges
        queue_load(0, 0);
        queue_load(511, 511);
        queue_load(170, 341);
        queue_load(341, 170);
        queue_load(512, 0);
        queue_load(0, 512);
        queue_load(4095, 4095);
        queue_sample(0, 0);
        queue_sample(511, 511);
        queue_sample(255, 128);
        queue_sample(1, 510);
        queue_sample(512, 0);
        queue_sample(0, 512);
        queue_sample(4095, 4095);
        queue_sample(2730, 1365);
        wait_idle();

        for (int p = 0; p < 7; p++) begin
            // Sender-light then receiver-light stalls, then free-running
            if (p < 3) begin
                snd_idle_pct = 19;
                rcv_idle_pct = 80;
            end else if (p < 5) begin
                snd_idle_pct = 80;
                rcv_idle_pct = 19;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            write_reg(REG_SRC_WIDTH,  phase_cfg[p][0]);
            write_reg(REG_SRC_HEIGHT, phase_cfg[p][1]);
            write_reg(REG_DST_WIDTH,  phase_cfg[p][2]);
            write_reg(REG_DST_HEIGHT, phase_cfg[p][3]);
            write_reg(REG_CH_COUNT,   phase_cfg[p][4]);
            if (p == 1 || p == 5) hold_token++;
            for (int n = 0; n < phase_cfg[p][5]; n++) begin
                if ($urandom_range(9) < 7)
                    queue_sample(rand_coord(dst_w_reg), rand_coord(dst_h_reg));
                else
                    queue_load(rand_coord(eff_src_w()), rand_coord(eff_src_h()));
            end
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/bis_pkg.sv
rtl/bilinear_image_scaler.sv
sim/bilinear_image_scaler_tb.sv
